FILE: rtl/vn3d_pkg.sv
// package for the 3d lattice value noise block
// constants, types and hash helpers shared by all modules; no dependencies
package vn3d_pkg;

  localparam int LATTICE_BITS = 8;
  localparam int LB = LATTICE_BITS;

  // depth of the valid and out-of-range flag pipes of the back part
  localparam int BACK_STAGES = 12;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] HN = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;
  localparam logic [31:0] SEED = 32'd42;

  typedef struct packed {
    logic signed [LB-1:0] x;
    logic signed [LB-1:0] y;
    logic signed [LB-1:0] z;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fz;
    logic oor;
  } cell_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

  // exact float bits of a key below 2^24 in magnitude
  function automatic logic [31:0] key_bits(input logic signed [24:0] k);
    logic [24:0] m;
    logic [4:0] e;
    logic [31:0] sh;
    m = k[24] ? 25'(-k) : k;
    e = '0;
    for (int i = 0; i < 25; i++) begin
      if (m[i]) e = 5'(i);
    end
    sh = 32'(m) << (5'd23 - e);
    if (m == '0) key_bits = '0;
    else key_bits = {k[24], 8'(e) + 8'd127, sh[22:0]};
  endfunction

endpackage

FILE: rtl/vn3d_front.sv
// front: scales the point by the frequency and splits into cell and fractions
// depends on vn3d_pkg
module vn3d_front import vn3d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [23:0] px,
  input  logic signed [23:0] py,
  input  logic signed [23:0] pz,
  input  logic [15:0] freq,
  output logic out_valid,
  output cell_t lat
);
  logic signed [40:0] prx, pry, prz;
  logic v1;

  always_ff @(posedge clk) begin
    prx <= px * $signed({1'b0, freq});
    pry <= py * $signed({1'b0, freq});
    prz <= pz * $signed({1'b0, freq});
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
  end

  function automatic logic ok(input logic signed [40:0] p);
    logic signed [16:0] ip;
    ip = p[40:24];
    ok = (ip >= -(17'sd1 <<< (LB-1))) && (ip <= ((17'sd1 <<< (LB-1)) - 17'sd1));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    lat.x <= prx[24+LB-1:24];
    lat.y <= pry[24+LB-1:24];
    lat.z <= prz[24+LB-1:24];
    lat.fx <= prx[23:8];
    lat.fy <= pry[23:8];
    lat.fz <= prz[23:8];
    lat.oor <= !(ok(prx) && ok(pry) && ok(prz));
  end
endmodule

FILE: rtl/vn3d_queue.sv
// two-entry queue between front and back
// depends on vn3d_pkg
module vn3d_queue import vn3d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cell_t wdata,
  output logic rd_valid,
  output cell_t rdata
);
  cell_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign rd_valid = cnt != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd_valid) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd_valid);
    end
  end
endmodule

FILE: rtl/vn3d_back.sv
// back: corner hashes, smoothstep weights and trilinear blend, pipelined
// depends on vn3d_pkg
module vn3d_back import vn3d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cell_t lat,
  output logic out_valid,
  output logic signed [15:0] noise,
  output logic out_of_range
);
  logic [BACK_STAGES-1:0] v;
  logic oor [BACK_STAGES];
  logic [15:0] fx, fy, fz;

  logic signed [24:0] key [8];
  logic [31:0] kb [8], m1 [8], m2 [8], h1 [8], h2 [8], h3 [8], h4 [8];
  logic signed [16:0] c [8];

  logic [31:0] tt [3];
  logic [15:0] tq [3];
  logic [63:0] t3 [3];
  logic [63:0] t2 [3];
  logic [16:0] w [3];

  logic signed [16:0] a4 [4];
  logic signed [16:0] a2 [2];
  logic signed [16:0] a1;
  logic [16:0] wzr [4:8];
  logic [16:0] wyr [4:9];
  logic [16:0] wxr [4:10];

  function automatic logic signed [16:0] mix(input logic signed [16:0] a,
      input logic signed [16:0] b, input logic [16:0] wt);
    logic signed [35:0] s;
    s = 36'(a) * $signed({1'b0, 17'(17'h10000 - wt)}) + 36'(b) * $signed({1'b0, wt})
        + 36'sd32768;
    mix = 17'(s >>> 16);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else v <= {v[BACK_STAGES-2:0], in_valid};
    oor[0] <= lat.oor;
    fx <= lat.fx;
    fy <= lat.fy;
    fz <= lat.fz;
    for (int s = 1; s < BACK_STAGES; s++) oor[s] <= oor[s-1];
    for (int s = 5; s <= 8; s++) wzr[s] <= wzr[s-1];
    for (int s = 5; s <= 9; s++) wyr[s] <= wyr[s-1];
    for (int s = 5; s <= 10; s++) wxr[s] <= wxr[s-1];
    for (int n = 0; n < 8; n++) begin
      key[n] <= (25'(lat.x) + 25'(n[2])) + ((25'(lat.y) + 25'(n[1])) << 7)
                + ((25'(lat.z) + 25'(n[0])) << 15);
      kb[n] <= key_bits(key[n]);
      m1[n] <= kb[n] * C1;
      m2[n] <= rotl(m1[n], 15) * C2;
      h1[n] <= (rotl(SEED ^ m2[n], 13) * 32'd5 + HN) ^ 32'd4;
      h2[n] <= (h1[n] ^ (h1[n] >> 16)) * F1;
      h3[n] <= (h2[n] ^ (h2[n] >> 13)) * F2;
      h4[n] <= h3[n] ^ (h3[n] >> 16);
      c[n] <= $signed({1'b0, h4[n][31:16]}) - 17'sd32768;
    end
    // weights: stage A tt, stage B products, stage C round
    tt[0] <= fx * fx;
    tt[1] <= fy * fy;
    tt[2] <= fz * fz;
    tq[0] <= fx;
    tq[1] <= fy;
    tq[2] <= fz;
    for (int a = 0; a < 3; a++) begin
      t3[a] <= 64'(tt[a]) * 64'(tq[a]) * 64'd2;
      t2[a] <= 64'(tt[a]) * 64'd196608;
      w[a] <= 17'((t2[a] - t3[a] + 64'h80000000) >> 32);
    end
    wzr[4] <= w[2];
    wyr[4] <= w[1];
    wxr[4] <= w[0];
    // blend after hash completes at stage 8
    for (int q = 0; q < 4; q++) a4[q] <= mix(c[2*q], c[2*q+1], wzr[8]);
    for (int q = 0; q < 2; q++) a2[q] <= mix(a4[2*q], a4[2*q+1], wyr[9]);
    a1 <= mix(a2[0], a2[1], wxr[10]);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v[BACK_STAGES-1];
    out_of_range <= oor[BACK_STAGES-1];
    noise <= oor[BACK_STAGES-1] ? 16'sd0 : a1[15:0];
  end
endmodule

FILE: rtl/value_noise_3d_lattice.sv
// top level of the 3d lattice value noise block
// depends on vn3d_pkg, vn3d_front, vn3d_queue, vn3d_back
// usage:
//   raise start with point_x/y/z (signed q8.16); busy is always low, so one
//   request may enter every cycle
//   frequency (unsigned q8.8) is written with cfg_we/cfg_wdata while idle
//   each request gives one result on noise/out_of_range, marked by done
//   for one cycle; results leave in request order
//   a request passes through 2 front stages, 1 queue slot and 13 back
//   stages before done rises with its result;
//   throughput one per cycle, set by the fully pipelined murmur3 hash and
//   blend stages
//   the receiver cannot stall; results must be taken when done is high
//   rst clears all valid flags and sets frequency to 1.0
//   out_of_range marks a cell outside the lattice; noise is then zero
module value_noise_3d_lattice import vn3d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic done,
  output logic signed [15:0] noise,
  output logic out_of_range
);
  logic [15:0] frequency;
  logic fv, qv;
  cell_t fc, qc;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) frequency <= 16'd256;
    else if (cfg_we) frequency <= cfg_wdata;
  end

  vn3d_front u_front (.clk, .rst, .in_valid(start), .px(point_x), .py(point_y),
    .pz(point_z), .freq(frequency), .out_valid(fv), .lat(fc));
  vn3d_queue u_queue (.clk, .rst, .wr(fv), .wdata(fc), .rd_valid(qv), .rdata(qc));
  vn3d_back u_back (.clk, .rst, .in_valid(qv), .lat(qc), .out_valid(done),
    .noise, .out_of_range);

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> noise == 16'sd0) else $error("oor noise nonzero");
  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    $past(rst, 16) == 1'b0 && done |-> $past(start, 16)) else $error("done without request");
endmodule

FILE: verif/tb_top.sv
// testbench for the 3d lattice value noise block
// predicts each result with a murmur3 hash and smoothstep blend, checks in order
// depends on vn3d_pkg and value_noise_3d_lattice
`timescale 1ns / 1ps
module tb_top;
  import vn3d_pkg::*;

  localparam int LATENCY = 16;

  typedef struct {
    logic signed [15:0] noise;
    logic               oor;
  } noise_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] point_x = '0, point_y = '0, point_z = '0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic done;
  logic signed [15:0] noise;
  logic out_of_range;

  logic [15:0] freq_q = 16'd256;
  noise_res_t expected_q[$];
  int errors = 0;
  bit no_idle = 1'b0;

  value_noise_3d_lattice i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .noise(noise), .out_of_range(out_of_range)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rotl32(logic [31:0] v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] float_bits(int k);
    logic [31:0] m;
    int e;
    logic [31:0] s;
    if (k == 0) return '0;
    s = (k < 0) ? 32'h8000_0000 : 32'h0;
    m = (k < 0) ? 32'(-k) : 32'(k);
    e = 0;
    while ((m >> (e + 1)) != 0) e++;
    return s | (32'(e + 127) << 23) | ((m << (23 - e)) & 32'h7fffff);
  endfunction

  function automatic int corner_hash(int x, int y, int z);
    logic [31:0] k, h;
    k = float_bits(x + 128 * y + 32768 * z);
    h = 32'd42;
    k = k * 32'hcc9e2d51;
    k = rotl32(k, 15);
    k = k * 32'h1b873593;
    h = h ^ k;
    h = rotl32(h, 13);
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return int'(h >> 16) - 32768;
  endfunction

  function automatic longint smooth(longint t);
    longint tt;
    tt = t * t;
    return (3 * tt * 65536 - 2 * tt * t + 64'h8000_0000) >>> 32;
  endfunction

  function automatic int blend(int a, int b, longint w1);
    longint s;
    s = longint'(a) * (65536 - w1) + longint'(b) * w1 + 32768;
    return int'(s >>> 16);
  endfunction

  function automatic noise_res_t predict_noise(logic signed [23:0] px,
      logic signed [23:0] py, logic signed [23:0] pz);
    noise_res_t r;
    longint p[3];
    int ip[3];
    longint w[3];
    int c[8];
    int v00, v10, v01, v11, v0, v1;
    bit bad;
    p[0] = px; p[1] = py; p[2] = pz;
    bad = 1'b0;
    for (int a = 0; a < 3; a++) begin
      p[a] = p[a] * longint'(freq_q);
      ip[a] = int'(p[a] >>> 24);
      w[a] = smooth((p[a] >>> 8) & 64'hffff);
      if (ip[a] < -(1 << (LATTICE_BITS - 1)) || ip[a] > (1 << (LATTICE_BITS - 1)) - 1)
        bad = 1'b1;
    end
    r.oor = bad;
    r.noise = '0;
    if (bad) return r;
    for (int n = 0; n < 8; n++)
      c[n] = corner_hash(ip[0] + n[2], ip[1] + n[1], ip[2] + n[0]);
    v00 = blend(c[0], c[1], w[2]);
    v01 = blend(c[2], c[3], w[2]);
    v10 = blend(c[4], c[5], w[2]);
    v11 = blend(c[6], c[7], w[2]);
    v0 = blend(v00, v01, w[1]);
    v1 = blend(v10, v11, w[1]);
    r.noise = 16'(blend(v0, v1, w[0]));
    return r;
  endfunction

  task automatic send_point(logic signed [23:0] px, logic signed [23:0] py,
      logic signed [23:0] pz);
    while (!no_idle && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    point_x <= px; point_y <= py; point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_noise(px, py, pz));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_frequency(logic [15:0] f);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    freq_q = f;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(1023)) - 512) <<< 14;
      default: return 24'($signed($urandom_range(16'hffff)) - 32768) <<< $urandom_range(8);
    endcase
  endfunction

  always @(posedge clk) begin
    noise_res_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending: noise %0d oor %0b", noise, out_of_range);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (noise !== e.noise) begin
          $error("noise expected %0d actual %0d", e.noise, noise);
          errors++;
        end
        if (out_of_range !== e.oor) begin
          $error("out_of_range expected %0b actual %0b", e.oor, out_of_range);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    logic signed [23:0] ext[6] = '{24'sh800000, 24'sh7fffff, 24'sh0, -24'sd1,
                                   24'sh7f0000, -24'sh800000};
    for (int i = 0; i < 6; i++)
      send_point(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
    send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_point(24'sh800000, 24'sh800000, 24'sh800000);
    send_point(24'sh00ffff, 24'sh008000, 24'sh000001);
  endtask

  task automatic test_zero_frequency();
    set_frequency(16'h0000);
    send_point(24'sh7fffff, 24'sh800000, 24'sh123456);
    send_point(24'sh0, 24'sh0, 24'sh0);
  endtask

  task automatic test_max_frequency();
    set_frequency(16'hffff);
    send_point(24'sh000000, 24'sh000100, -24'sd256);
    send_point(24'sh008000, -24'sh008000, 24'sh00ffff);
    send_point(24'sh7fffff, 24'sh0, 24'sh0);
  endtask

  task automatic test_random(int count);
    logic [15:0] freqs[5] = '{16'h0100, 16'h0040, 16'h0380, 16'h1000, 16'h00c3};
    for (int p = 0; p < 5; p++) begin
      set_frequency(p == 4 ? 16'($urandom) : freqs[p]);
      no_idle = (p == 2);
      for (int i = 0; i < count / 5; i++)
        send_point(rand_coord(), rand_coord(), rand_coord());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_zero_frequency();
    test_max_frequency();
    test_random(800);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
